// File: hw/rtl/chip8_execute_unit_assert.svh
// Assertion macros shared by the execute unit RTL.
`ifndef CHIP8_EXECUTE_UNIT_ASSERT_SVH
`define CHIP8_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define C8EXU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define C8EXU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/c8exu_pkg.sv
package c8exu_pkg;

  typedef enum logic [3:0] {
    KIND_LOADIMM  = 4'd0,
    KIND_SETINDEX = 4'd1,
    KIND_ADD      = 4'd2,
    KIND_SUB      = 4'd3,
    KIND_SUBN     = 4'd4,
    KIND_SHR      = 4'd5,
    KIND_SHL      = 4'd6,
    KIND_ADDINDEX = 4'd7,
    KIND_CALL     = 4'd8,
    KIND_RET      = 4'd9,
    KIND_EQREG    = 4'd10,
    KIND_EQIMM    = 4'd11,
    KIND_NEIMM    = 4'd12,
    KIND_BCD      = 4'd13,
    KIND_FETCH    = 4'd14
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_BOUNDS   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLAG,
    ST_BCD1,
    ST_BCD2
  } state_e;

  localparam logic [3:0]  FLAG_REG = 4'hF;
  localparam logic [15:0] PC_RESET = 16'h0200;

  typedef struct packed {
    logic       take_in;   // input beat accepted, RAM reads issued
    logic       load_out;  // result register loads this cycle
    logic       op_commit; // architectural update of the operation
    logic       flag_wr;   // VF write after the Vx write
    logic [1:0] digit;     // BCD digit being emitted
  } ctrl_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       wr_vx;
    logic       cond;
    logic [1:0] hund;
    logic [6:0] rem;
  } alu_res_t;

  // Tens and ones of a value below 100; 205/2048 stands in for 1/10.
  function automatic logic [7:0] bcd_split(input logic [6:0] val);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(val) * 15'd205;
    tens = prod[14:11];
    ones = val - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

// File: hw/rtl/c8exu_ram.sv
module c8exu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/c8exu_alu.sv
module c8exu_alu import c8exu_pkg::*; (
  input  kind_e      kind_i,
  input  logic [7:0] vx_i,
  input  logic [7:0] vy_i,
  input  logic [7:0] imm_i,
  output alu_res_t   res_o
);

  logic [8:0] sum;

  assign sum = {1'b0, vx_i} + {1'b0, vy_i};

  always_comb begin
    res_o = '0;
    unique case (kind_i)
      KIND_LOADIMM: begin
        res_o.res   = imm_i;
        res_o.wr_vx = 1'b1;
      end
      KIND_ADD: begin
        res_o.res   = sum[7:0];
        res_o.flag  = sum[8];
        res_o.wr_vx = 1'b1;
      end
      KIND_SUB: begin
        res_o.res   = vx_i - vy_i;
        res_o.flag  = (vx_i >= vy_i);
        res_o.wr_vx = 1'b1;
      end
      KIND_SUBN: begin
        res_o.res   = vy_i - vx_i;
        res_o.flag  = (vy_i >= vx_i);
        res_o.wr_vx = 1'b1;
      end
      KIND_SHR: begin
        res_o.res   = {1'b0, vx_i[7:1]};
        res_o.flag  = vx_i[0];
        res_o.wr_vx = 1'b1;
      end
      KIND_SHL: begin
        res_o.res   = {vx_i[6:0], 1'b0};
        res_o.flag  = vx_i[7];
        res_o.wr_vx = 1'b1;
      end
      KIND_EQREG: res_o.cond = (vx_i == vy_i);
      KIND_EQIMM: res_o.cond = (vx_i == imm_i);
      KIND_NEIMM: res_o.cond = (vx_i != imm_i);
      default: ;
    endcase

    // hundreds digit and remainder for BCD
    if (vx_i >= 8'd200) begin
      res_o.hund = 2'd2;
      res_o.rem  = 7'(vx_i - 8'd200);
    end else if (vx_i >= 8'd100) begin
      res_o.hund = 2'd1;
      res_o.rem  = 7'(vx_i - 8'd100);
    end else begin
      res_o.hund = 2'd0;
      res_o.rem  = vx_i[6:0];
    end
  end

endmodule

// File: hw/rtl/c8exu_ctrl.sv
module c8exu_ctrl import c8exu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_free_i,
  input  kind_e kind_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   has_flag;

  assign has_flag = (kind_i == KIND_ADD) || (kind_i == KIND_SUB) ||
                    (kind_i == KIND_SUBN) || (kind_i == KIND_SHR) ||
                    (kind_i == KIND_SHL);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (out_free_i) begin
          if (has_flag) begin
            state_d = ST_FLAG;
          end else if (kind_i == KIND_BCD) begin
            state_d = ST_BCD1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLAG: state_d = ST_IDLE;
      ST_BCD1: if (out_free_i) state_d = ST_BCD2;
      ST_BCD2: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: ctrl_o.take_in = in_valid_i;
      ST_EXEC: begin
        ctrl_o.load_out  = out_free_i;
        ctrl_o.op_commit = out_free_i;
      end
      ST_FLAG: ctrl_o.flag_wr = 1'b1;
      ST_BCD1: begin
        ctrl_o.load_out = out_free_i;
        ctrl_o.digit    = 2'd1;
      end
      ST_BCD2: begin
        ctrl_o.load_out = out_free_i;
        ctrl_o.digit    = 2'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/chip8_execute_unit.sv
// Execute unit for a CHIP-8 style CPU. V0..VF sit in a register-file RAM
// (two copies written together, so Vx and Vy are read in the same cycle) and
// the return stack in a second RAM; both have a registered read.
// An item is accepted in ST_IDLE and executed in ST_EXEC; add, sub, subn,
// shr and shl then pass through ST_FLAG, because the flag goes into VF
// through the single write port after the Vx write; BCD passes through
// ST_BCD1 and ST_BCD2 and emits its three digit writes on consecutive beats.
// A stalled result beat holds execution in place. The input is taken only
// while no operation is in flight, which keeps register-file reads clear of
// pending writes. Results carry the program counter after the operation.
`include "chip8_execute_unit_assert.svh"

module chip8_execute_unit import c8exu_pkg::*; #(
  parameter int MEM_SIZE    = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // reg_x[3:0], reg_y[7:4], immediate[19:8], zero
  input  logic [3:0]  s_axis_tuser,  // kind[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status[1:0], cond[2], pc_out[18:3],
                                     // write_valid[19], write_addr[35:20],
                                     // write_data[43:36], zero
  output logic        m_axis_tlast   // last
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);

  ctrl_t    ctrl;
  alu_res_t alu;
  logic     out_free;

  kind_e       kind_q;
  logic [3:0]  x_q, y_q;
  logic [11:0] imm_q;
  logic        vx_ok_q, vy_ok_q;

  logic [15:0]   pc_q, pc_d;
  logic [15:0]   idx_q, idx_d;
  logic [DW-1:0] depth_q, depth_d, depth_dec;
  logic [15:0]   rf_valid_q, rf_valid_d;
  logic          flag_q;
  logic [6:0]    rem_q;
  logic [3:0]    ones_q;
  logic [7:0]    split;

  logic [7:0]  rfa_rdata, rfb_rdata, vx, vy;
  logic        rf_we;
  logic [3:0]  rf_waddr;
  logic [7:0]  rf_wdata;
  logic        stk_we;
  logic [15:0] stk_rdata;

  logic        m_valid_q, m_valid_d;
  logic [43:0] m_data_q, m_data_d;
  logic        m_last_q, m_last_d;

  status_e     status;
  logic        cond, wr_valid, last;
  logic [15:0] wr_addr;
  logic [7:0]  wr_data;

  assign out_free = !m_valid_q || m_axis_tready;

  c8exu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .kind_i     (kind_q),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.take_in;

  // operand registers, captured with the input beat
  always_ff @(posedge clk_i) begin
    if (ctrl.take_in) begin
      kind_q  <= kind_e'(s_axis_tuser);
      x_q     <= s_axis_tdata[3:0];
      y_q     <= s_axis_tdata[7:4];
      imm_q   <= s_axis_tdata[19:8];
      vx_ok_q <= rf_valid_q[s_axis_tdata[3:0]];
      vy_ok_q <= rf_valid_q[s_axis_tdata[7:4]];
    end
  end

  assign rf_we    = (ctrl.op_commit && alu.wr_vx) || ctrl.flag_wr;
  assign rf_waddr = ctrl.flag_wr ? FLAG_REG : x_q;
  assign rf_wdata = ctrl.flag_wr ? {7'd0, flag_q} : alu.res;

  c8exu_ram #(.WIDTH(8), .DEPTH(16)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (ctrl.take_in),
    .raddr_i (s_axis_tdata[3:0]),
    .rdata_o (rfa_rdata)
  );

  c8exu_ram #(.WIDTH(8), .DEPTH(16)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (ctrl.take_in),
    .raddr_i (s_axis_tdata[7:4]),
    .rdata_o (rfb_rdata)
  );

  // never-written registers read as zero
  assign vx = vx_ok_q ? rfa_rdata : 8'd0;
  assign vy = vy_ok_q ? rfb_rdata : 8'd0;

  always_comb begin
    rf_valid_d = rf_valid_q;
    if (rf_we) begin
      rf_valid_d[rf_waddr] = 1'b1;
    end
  end

  c8exu_alu u_alu (
    .kind_i (kind_q),
    .vx_i   (vx),
    .vy_i   (vy),
    .imm_i  (imm_q[7:0]),
    .res_o  (alu)
  );

  assign depth_dec = depth_q - DW'(1);

  c8exu_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[SAW-1:0]),
    .wdata_i (pc_q),
    .re_i    (ctrl.take_in),
    .raddr_i (depth_dec[SAW-1:0]),
    .rdata_o (stk_rdata)
  );

  assign split = bcd_split(rem_q);

  // architectural update and result fields
  always_comb begin
    pc_d     = pc_q;
    idx_d    = idx_q;
    depth_d  = depth_q;
    stk_we   = 1'b0;
    status   = STATUS_OK;
    cond     = 1'b0;
    wr_valid = 1'b0;
    wr_addr  = 16'd0;
    wr_data  = 8'd0;
    last     = 1'b1;
    if (ctrl.op_commit) begin
      cond = alu.cond;
      unique case (kind_q)
        KIND_SETINDEX: idx_d = {4'd0, imm_q};
        KIND_ADDINDEX: idx_d = idx_q + {8'd0, vx};
        KIND_CALL: begin
          if (depth_q >= DW'(STACK_DEPTH)) begin
            status = STATUS_OVERFLOW;
          end else begin
            stk_we  = 1'b1;
            depth_d = depth_q + DW'(1);
            pc_d    = {4'd0, imm_q};
          end
        end
        KIND_RET: begin
          if (depth_q == '0) begin
            status = STATUS_EMPTY;
          end else begin
            depth_d = depth_dec;
            pc_d    = stk_rdata;
          end
        end
        KIND_FETCH: begin
          if ({1'b0, pc_q} >= 17'(MEM_SIZE)) begin
            status = STATUS_BOUNDS;
          end else begin
            pc_d = pc_q + 16'd2;
          end
        end
        KIND_BCD: begin
          wr_valid = 1'b1;
          wr_addr  = idx_q;
          wr_data  = {6'd0, alu.hund};
          last     = 1'b0;
        end
        default: ;
      endcase
    end else if (ctrl.digit == 2'd1) begin
      wr_valid = 1'b1;
      wr_addr  = idx_q + 16'd1;
      wr_data  = {4'd0, split[7:4]};
      last     = 1'b0;
    end else if (ctrl.digit == 2'd2) begin
      wr_valid = 1'b1;
      wr_addr  = idx_q + 16'd2;
      wr_data  = {4'd0, ones_q};
    end
  end

  assign m_data_d  = {wr_data, wr_addr, wr_valid, pc_d, cond, status};
  assign m_last_d  = last;
  assign m_valid_d = ctrl.load_out ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      m_data_q <= m_data_d;
      m_last_q <= m_last_d;
    end
    if (ctrl.op_commit) begin
      flag_q <= alu.flag;
      rem_q  <= alu.rem;
    end
    if (ctrl.digit == 2'd1) begin
      ones_q <= split[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= PC_RESET;
      idx_q      <= 16'd0;
      depth_q    <= '0;
      rf_valid_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      pc_q       <= pc_d;
      idx_q      <= idx_d;
      depth_q    <= depth_d;
      rf_valid_q <= rf_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_data_q};
  assign m_axis_tlast  = m_last_q;

  `C8EXU_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DW'(STACK_DEPTH), "stack depth beyond limit")
  `C8EXU_ASSERT_NOW(a_no_rf_overlap, ctrl.take_in, !rf_we, "register file read meets a write")
  `C8EXU_ASSERT_NEXT(a_push, stk_we, depth_q == DW'($past(depth_q) + DW'(1)), "push lost")
  `C8EXU_ASSERT_NEXT(a_flag_after_exec, ctrl.op_commit && kind_q == KIND_ADD, ctrl.flag_wr,
                     "flag write missing after add")

endmodule
